// ===== design/assert_macros.svh =====
// Assertion macros used by the sequencer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge while out of reset.
`define BEPS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Checks that a condition is never seen on a rising clock edge while out of reset.
`define BEPS_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

// ===== design/bepseq_pkg.sv =====
// Types, phase codes and script tables for the boot entry pin sequencer.
package bepseq_pkg;

  localparam int unsigned WaitW   = 16;
  localparam int unsigned StepW   = 4;
  localparam int unsigned HoldW   = 7;
  localparam int unsigned PhaseW  = 2;
  localparam logic [StepW-1:0] LastStep = StepW'(5);

  localparam logic [PhaseW-1:0] PH_IDLE     = 2'd0;
  localparam logic [PhaseW-1:0] PH_DEBOUNCE = 2'd1;
  localparam logic [PhaseW-1:0] PH_SCRIPT   = 2'd2;

  localparam logic LINE_TEST  = 1'b0;
  localparam logic LINE_RESET = 1'b1;

  localparam logic [WaitW-1:0] DebounceReset = 16'd50000;

  typedef struct packed {
    logic             line;
    logic             level;
    logic [HoldW-1:0] hold;
  } seg_t;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [WaitW-1:0]  wait_count;
    logic [StepW-1:0]  script_step;
    logic              boot_mode;
    logic              armed;
    logic              test_level;
    logic              reset_level;
    logic              led_level;
  } state_t;

  typedef struct packed {
    logic test_line;
    logic reset_line;
    logic led_on;
    logic in_boot_mode;
    logic busy_res;
  } res_t;

  // One step of the entry or exit waveform; steps past the end read as the last one.
  function automatic seg_t script_seg(input logic exit_script, input logic [StepW-1:0] k);
    seg_t s;
    s = '{line: LINE_TEST, level: 1'b0, hold: '0};
    if (!exit_script) begin
      case (k)
        4'd0:    s = '{line: LINE_RESET, level: 1'b0, hold: 7'd50};
        4'd1:    s = '{line: LINE_TEST,  level: 1'b1, hold: 7'd30};
        4'd2:    s = '{line: LINE_TEST,  level: 1'b0, hold: 7'd8};
        4'd3:    s = '{line: LINE_TEST,  level: 1'b1, hold: 7'd15};
        4'd4:    s = '{line: LINE_RESET, level: 1'b1, hold: 7'd15};
        default: s = '{line: LINE_TEST,  level: 1'b0, hold: 7'd0};
      endcase
    end else begin
      case (k)
        4'd0:    s = '{line: LINE_TEST,  level: 1'b1, hold: 7'd30};
        4'd1:    s = '{line: LINE_TEST,  level: 1'b0, hold: 7'd30};
        4'd2:    s = '{line: LINE_TEST,  level: 1'b1, hold: 7'd30};
        4'd3:    s = '{line: LINE_TEST,  level: 1'b0, hold: 7'd60};
        4'd4:    s = '{line: LINE_RESET, level: 1'b0, hold: 7'd60};
        default: s = '{line: LINE_RESET, level: 1'b1, hold: 7'd0};
      endcase
    end
    return s;
  endfunction

endpackage

// ===== design/boot_entry_pin_sequencer_unit.sv =====
// Top level of the boot entry pin sequencer: state registers, config register, result stage.
//
//   channel | direction | payload
//   in      | request in  | button_pressed_i
//   out     | request out | test_line_o, reset_line_o, led_on_o, in_boot_mode_o, busy_res_o
//   cfg     | write in    | cfg_debounce_ticks_i
//
// One request per cycle unless the output stalls; its result is registered the next cycle.
// The rate is set by the single state update between the state and result registers.
// A stalled output takes a new request in the cycle that the held result leaves.
// Reset returns to idle, armed, both lines low and debounce length 50000 ticks.
`include "assert_macros.svh"

module boot_entry_pin_sequencer_unit import bepseq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             button_pressed_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             test_line_o,
  output logic             reset_line_o,
  output logic             led_on_o,
  output logic             in_boot_mode_o,
  output logic             busy_res_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [WaitW-1:0] cfg_debounce_ticks_i
);

  state_t           state_d, state_q;
  logic [WaitW-1:0] debounce_q;
  res_t             res_d, res_q;
  logic             space;
  logic             accept;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = space;
  assign accept      = in_valid_i && space;

  bepseq_next u_next (
    .state_i          (state_q),
    .pressed_i        (button_pressed_i),
    .debounce_ticks_i (debounce_q),
    .state_o          (state_d),
    .res_o            (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_IDLE, wait_count: '0, script_step: '0, boot_mode: 1'b0,
                   armed: 1'b1, test_level: 1'b0, reset_level: 1'b0, led_level: 1'b0};
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DebounceReset;
    end else if (cfg_valid_i) begin
      debounce_q <= cfg_debounce_ticks_i;
    end
  end

  bepseq_oreg u_oreg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .res_i       (res_d),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .space_o     (space),
    .res_o       (res_q)
  );

  assign test_line_o    = res_q.test_line;
  assign reset_line_o   = res_q.reset_line;
  assign led_on_o       = res_q.led_on;
  assign in_boot_mode_o = res_q.in_boot_mode;
  assign busy_res_o     = res_q.busy_res;

  // A script only runs once the block has disarmed.
  `BEPS_NEVER(a_script_disarmed, clk_i, rst_ni,
    (state_q.phase == PH_SCRIPT) && state_q.armed)
  // The countdown is cleared whenever the block is idle.
  `BEPS_ASSERT(a_idle_no_wait, clk_i, rst_ni,
    (state_q.phase == PH_IDLE) |-> (state_q.wait_count == '0))
  // The LED always follows the boot mode in the state.
  `BEPS_ASSERT(a_led_mode, clk_i, rst_ni,
    state_q.led_level == state_q.boot_mode)
  // The state moves only when a request is taken.
  `BEPS_ASSERT(a_state_hold, clk_i, rst_ni,
    !accept |=> $stable(state_q))

endmodule

// ===== design/bepseq_next.sv =====
// Next-state logic for one tick: debounce countdown and script stepping.
module bepseq_next import bepseq_pkg::*; (
  input  state_t           state_i,
  input  logic             pressed_i,
  input  logic [WaitW-1:0] debounce_ticks_i,
  output state_t           state_o,
  output res_t             res_o
);

  state_t           st;
  state_t           ran;
  seg_t             seg;
  logic [StepW-1:0] k;
  logic [StepW-1:0] k_run;
  logic             wait_more;

  // The debounce check starts the script at step zero, so a script step is taken from there.
  assign k_run     = (state_i.phase == PH_DEBOUNCE) ? '0 : state_i.script_step;
  assign k         = (k_run > LastStep) ? LastStep : k_run;
  assign seg       = script_seg(state_i.boot_mode, k);
  assign wait_more = (state_i.wait_count > WaitW'(1));

  always_comb begin
    ran = state_i;
    if (seg.line == LINE_TEST) begin
      ran.test_level = seg.level;
    end else begin
      ran.reset_level = seg.level;
    end
    if (k == LastStep) begin
      ran.boot_mode   = ~state_i.boot_mode;
      ran.led_level   = ~state_i.boot_mode;
      ran.phase       = PH_IDLE;
      ran.wait_count  = '0;
      ran.script_step = '0;
    end else begin
      ran.phase       = PH_SCRIPT;
      ran.wait_count  = WaitW'(seg.hold);
      ran.script_step = k + StepW'(1);
    end
  end

  always_comb begin
    st = state_i;
    case (state_i.phase)
      PH_DEBOUNCE: begin
        if (wait_more) begin
          st.wait_count = state_i.wait_count - WaitW'(1);
        end else if (pressed_i) begin
          st       = ran;
          st.armed = 1'b0;
        end else begin
          st.phase      = PH_IDLE;
          st.wait_count = '0;
          st.armed      = 1'b1;
        end
      end
      PH_SCRIPT: begin
        if (wait_more) begin
          st.wait_count = state_i.wait_count - WaitW'(1);
        end else begin
          st = ran;
        end
      end
      default: begin
        st.phase = PH_IDLE;
        if (pressed_i && state_i.armed) begin
          st.phase      = PH_DEBOUNCE;
          st.wait_count = debounce_ticks_i;
        end else if (!pressed_i) begin
          st.armed = 1'b1;
        end
      end
    endcase
  end

  assign state_o = st;
  assign res_o   = '{test_line:    st.test_level,
                     reset_line:   st.reset_level,
                     led_on:       st.led_level,
                     in_boot_mode: st.boot_mode,
                     busy_res:     (st.phase == PH_DEBOUNCE) || (st.phase == PH_SCRIPT)};

endmodule

// ===== design/bepseq_oreg.sv =====
// Result register with valid flag; a new result may enter as the old one leaves.
module bepseq_oreg import bepseq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  res_t res_i,
  input  logic out_ready_i,
  output logic out_valid_o,
  output logic space_o,
  output res_t res_o
);

  logic out_valid_d, out_valid_q;
  res_t res_q;

  assign space_o     = !out_valid_q || out_ready_i;
  assign out_valid_d = load_i || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule
